[hdl/cpu_util_pkg.sv]
// Shared types and constants for the per-core busy-percentage monitor.
// No dependencies; imported by cpu_utilization_monitor.
package cpu_util_pkg;

   // Default core count handed to the top-level parameter
   localparam int MAX_CORES_DEF = 32;

   // Width of the shared add/subtract unit: 64-bit operands plus two guard bits
   localparam int UNIT_W = 66;

   // Restoring divide: one quotient bit per step
   localparam int DIV_STEPS = 64;

   localparam logic [6:0] PCT_FULL = 7'd100;
   localparam logic [6:0] PCT_NONE = 7'd0;
   localparam logic [5:0] ONLINE_RESET = 6'd1;
   localparam logic [7:0] NEST_MAX = 8'd255;

   // Command codes
   localparam logic [1:0] CMD_ENTER  = 2'd0;
   localparam logic [1:0] CMD_LEAVE  = 2'd1;
   localparam logic [1:0] CMD_SAMPLE = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [5:0]  core_index;
      logic [63:0] cycle_stamp;
      logic [63:0] tick_stamp;
      logic [63:0] core_busy_ticks;
   } req_type;

   typedef struct packed {
      logic [6:0] busy_percent;
      logic [5:0] sampled_core;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_LEAVE_GAP,
      ST_LEAVE_ADD,
      ST_C0_GAP,
      ST_C0_IDLE,
      ST_C0_DCYC,
      ST_C0_DIDLE,
      ST_OT_DTICK,
      ST_OT_DBUSY,
      ST_CHECK,
      ST_DIFF,
      ST_MUL1,
      ST_MUL2,
      ST_ROUND,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

[hdl/cpu_utilization_monitor.sv]
// Per-core busy-percentage monitor: idle nesting, idle-cycle accounting and sampling.
// Depends on cpu_util_pkg (types, command codes, constants).
//
//  channel   ports                        direction  handshake
//  request   start, busy, req_data        in         taken when start & !busy
//  result    rsp_valid, rsp_data          out        one-cycle strobe, no back-pressure
//  config    csr_we, csr_wdata            in         written when csr_we
//
// Enter and leave idle finish in ST_IDLE; a leave that closes the outermost idle
// period then runs ST_LEAVE_GAP and ST_LEAVE_ADD. An out-of-range sample answers
// the cycle after it is taken, a cached sample once ST_READ holds the history word.
// A computed sample ends in the 64-step radix-2 divide on the shared 66-bit adder.
// busy is high outside ST_IDLE; the receiver cannot stall the result.
// Synchronous reset; per-core history is held in memories flagged by valid bits,
// so there is no clearing pass after reset.
module cpu_utilization_monitor #(
   parameter int MAX_CORES = cpu_util_pkg::MAX_CORES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cpu_util_pkg::req_type req_data,
   output logic                  rsp_valid,
   output cpu_util_pkg::rsp_type rsp_data,
   input  logic                  csr_we,
   input  logic [5:0]            csr_wdata
);
   import cpu_util_pkg::*;

   localparam int IDX_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
   localparam logic [6:0] CORES_LIM = 7'(MAX_CORES);
   localparam logic [5:0] LAST_STEP = 6'(DIV_STEPS - 1);

   // Control state
   state_type          state_ff, state_in;
   logic [7:0]         nest_ff, nest_in;
   logic [5:0]         online_ff, online_in;
   logic [MAX_CORES-1:0] sampled_ff, sampled_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         cnt_ff, cnt_in;

   // Architectural 64-bit state
   logic [63:0] begin_ff, begin_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] prev_cyc_ff, prev_cyc_in;
   logic [63:0] prev_idle_ff, prev_idle_in;

   // Latched item and working registers
   logic [5:0]  core_ff, core_in;
   logic [63:0] cyc_ff, cyc_in;
   logic [63:0] tick_ff, tick_in;
   logic [63:0] busyt_ff, busyt_in;
   logic        first_ff, first_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] n_ff, n_in;
   logic [63:0] rem_ff, rem_in;
   logic [6:0]  rsp_pct_ff, rsp_pct_in;
   logic [5:0]  rsp_core_ff, rsp_core_in;

   // Per-core history memories, registered read
   logic [63:0] tick_mem [MAX_CORES];
   logic [63:0] busy_mem [MAX_CORES];
   logic [6:0]  pct_mem  [MAX_CORES];
   logic [63:0] rd_tick_ff, rd_busy_ff;
   logic [6:0]  rd_pct_ff;
   logic        hist_we, busy_we, pct_we;
   logic [6:0]  pct_wdata;

   // Shared add/subtract unit
   logic [UNIT_W-1:0] unit_a, unit_b, unit_sum;
   logic              unit_sub;

   logic             accept;
   logic             req_in_range;
   logic [IDX_W-1:0] req_idx, core_idx;
   logic             core_is0;
   logic [63:0]      prev_tick_v, prev_busy_v;

   assign accept   = start && !busy;
   assign req_idx  = req_data.core_index[IDX_W-1:0];
   assign core_idx = core_ff[IDX_W-1:0];
   assign core_is0 = (core_ff == 6'd0);
   assign req_in_range = ({1'b0, req_data.core_index} < CORES_LIM) &&
                         (req_data.core_index < online_ff);

   // History reads as zero before the first sample of a core
   assign prev_tick_v = first_ff ? 64'd0 : rd_tick_ff;
   assign prev_busy_v = first_ff ? 64'd0 : rd_busy_ff;

   assign unit_sum = unit_a + (unit_sub ? ~unit_b : unit_b) + UNIT_W'(unit_sub);

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.busy_percent = rsp_pct_ff;
   assign rsp_data.sampled_core = rsp_core_ff;

   // Sequencer: next state, datapath operands and register updates
   always_comb begin
      state_in     = state_ff;
      nest_in      = nest_ff;
      online_in    = csr_we ? csr_wdata : online_ff;
      sampled_in   = sampled_ff;
      rsp_valid_in = 1'b0;
      cnt_in       = cnt_ff;
      begin_in     = begin_ff;
      total_in     = total_ff;
      prev_cyc_in  = prev_cyc_ff;
      prev_idle_in = prev_idle_ff;
      core_in      = core_ff;
      cyc_in       = cyc_ff;
      tick_in      = tick_ff;
      busyt_in     = busyt_ff;
      first_in     = first_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_core_in  = rsp_core_ff;
      hist_we      = 1'b0;
      busy_we      = 1'b0;
      pct_we       = 1'b0;
      pct_wdata    = PCT_NONE;
      unit_a       = '0;
      unit_b       = '0;
      unit_sub     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               core_in  = req_data.core_index;
               cyc_in   = req_data.cycle_stamp;
               tick_in  = req_data.tick_stamp;
               busyt_in = req_data.core_busy_ticks;
               case (req_data.cmd)
                  CMD_ENTER: begin
                     if (nest_ff == 8'd0) begin
                        begin_in = req_data.cycle_stamp;
                     end
                     if (nest_ff != NEST_MAX) begin
                        nest_in = nest_ff + 8'd1;
                     end
                  end
                  CMD_LEAVE: begin
                     if (nest_ff != 8'd0) begin
                        nest_in = nest_ff - 8'd1;
                        if (nest_ff == 8'd1) begin
                           state_in = ST_LEAVE_GAP;
                        end
                     end
                  end
                  CMD_SAMPLE: begin
                     if (req_in_range) begin
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_pct_in   = PCT_NONE;
                        rsp_core_in  = req_data.core_index;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Closing the outermost idle period: total += cyc - begin
         ST_LEAVE_GAP: begin
            unit_a   = {2'b00, cyc_ff};
            unit_b   = {2'b00, begin_ff};
            unit_sub = 1'b1;
            a_in     = unit_sum[63:0];
            state_in = ST_LEAVE_ADD;
         end
         ST_LEAVE_ADD: begin
            unit_a   = {2'b00, total_ff};
            unit_b   = {2'b00, a_ff};
            total_in = unit_sum[63:0];
            state_in = ST_IDLE;
         end

         // History word is ready: cached answer or start of a fresh sample
         ST_READ: begin
            first_in = !sampled_ff[core_idx];
            if (sampled_ff[core_idx] && (tick_ff == rd_tick_ff)) begin
               rsp_valid_in = 1'b1;
               rsp_pct_in   = rd_pct_ff;
               rsp_core_in  = core_ff;
               state_in     = ST_IDLE;
            end else begin
               sampled_in[core_idx] = 1'b1;
               hist_we  = 1'b1;
               busy_we  = !core_is0;
               state_in = core_is0 ? ST_C0_GAP : ST_OT_DTICK;
            end
         end

         // Core 0: idle_now = total + (nested ? cyc - begin : 0)
         ST_C0_GAP: begin
            unit_a   = {2'b00, cyc_ff};
            unit_b   = {2'b00, begin_ff};
            unit_sub = 1'b1;
            a_in     = (nest_ff != 8'd0) ? unit_sum[63:0] : 64'd0;
            state_in = ST_C0_IDLE;
         end
         ST_C0_IDLE: begin
            unit_a   = {2'b00, total_ff};
            unit_b   = {2'b00, a_ff};
            b_in     = unit_sum[63:0];
            state_in = ST_C0_DCYC;
         end
         ST_C0_DCYC: begin
            unit_a   = {2'b00, cyc_ff};
            unit_b   = {2'b00, prev_cyc_ff};
            unit_sub = 1'b1;
            a_in     = first_ff ? 64'd0 : unit_sum[63:0];
            state_in = ST_C0_DIDLE;
         end
         ST_C0_DIDLE: begin
            unit_a       = {2'b00, b_ff};
            unit_b       = {2'b00, prev_idle_ff};
            unit_sub     = 1'b1;
            b_in         = first_ff ? 64'd0 : unit_sum[63:0];
            prev_idle_in = b_ff;
            prev_cyc_in  = cyc_ff;
            state_in     = ST_CHECK;
         end

         // Other cores: tick and busy deltas
         ST_OT_DTICK: begin
            unit_a   = {2'b00, tick_ff};
            unit_b   = {2'b00, prev_tick_v};
            unit_sub = 1'b1;
            a_in     = unit_sum[63:0];
            state_in = ST_OT_DBUSY;
         end
         ST_OT_DBUSY: begin
            unit_a   = {2'b00, busyt_ff};
            unit_b   = {2'b00, prev_busy_v};
            unit_sub = 1'b1;
            b_in     = unit_sum[63:0];
            state_in = ST_CHECK;
         end

         // a = elapsed, b = idle (core 0) or busy (others)
         ST_CHECK: begin
            unit_a   = {2'b00, b_ff};
            unit_b   = {2'b00, a_ff};
            unit_sub = 1'b1;
            if (a_ff == 64'd0) begin
               rsp_valid_in = 1'b1;
               rsp_pct_in   = PCT_NONE;
               rsp_core_in  = core_ff;
               pct_we       = 1'b1;
               pct_wdata    = PCT_NONE;
               state_in     = ST_IDLE;
            end else if (!unit_sum[UNIT_W-1]) begin
               rsp_valid_in = 1'b1;
               rsp_pct_in   = core_is0 ? PCT_NONE : PCT_FULL;
               rsp_core_in  = core_ff;
               pct_we       = 1'b1;
               pct_wdata    = core_is0 ? PCT_NONE : PCT_FULL;
               state_in     = ST_IDLE;
            end else begin
               state_in = core_is0 ? ST_DIFF : ST_MUL1;
            end
         end
         ST_DIFF: begin
            unit_a   = {2'b00, a_ff};
            unit_b   = {2'b00, b_ff};
            unit_sub = 1'b1;
            b_in     = unit_sum[63:0];
            state_in = ST_MUL1;
         end

         // n = b * 100 as 64b + 32b, then + 4b
         ST_MUL1: begin
            unit_a   = {2'b00, b_ff[57:0], 6'd0};
            unit_b   = {2'b00, b_ff[58:0], 5'd0};
            n_in     = unit_sum[63:0];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            unit_a   = {2'b00, n_ff};
            unit_b   = {2'b00, b_ff[61:0], 2'd0};
            n_in     = unit_sum[63:0];
            rem_in   = 64'd0;
            cnt_in   = 6'd0;
            state_in = core_is0 ? ST_ROUND : ST_DIV;
         end
         ST_ROUND: begin
            unit_a   = {2'b00, n_ff};
            unit_b   = {3'b000, a_ff[63:1]};
            n_in     = unit_sum[63:0];
            state_in = ST_DIV;
         end

         // Restoring divide n / a, quotient shifts into n
         ST_DIV: begin
            unit_a   = {1'b0, rem_ff, n_ff[63]};
            unit_b   = {2'b00, a_ff};
            unit_sub = 1'b1;
            if (!unit_sum[UNIT_W-1]) begin
               rem_in = unit_sum[63:0];
            end else begin
               rem_in = {rem_ff[62:0], n_ff[63]};
            end
            n_in   = {n_ff[62:0], !unit_sum[UNIT_W-1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            pct_wdata    = (n_ff > 64'(PCT_FULL)) ? PCT_FULL : n_ff[6:0];
            pct_we       = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_pct_in   = pct_wdata;
            rsp_core_in  = core_ff;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nest_ff      <= 8'd0;
         online_ff    <= ONLINE_RESET;
         sampled_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 6'd0;
         begin_ff     <= 64'd0;
         total_ff     <= 64'd0;
         prev_cyc_ff  <= 64'd0;
         prev_idle_ff <= 64'd0;
      end else begin
         state_ff     <= state_in;
         nest_ff      <= nest_in;
         online_ff    <= online_in;
         sampled_ff   <= sampled_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         begin_ff     <= begin_in;
         total_ff     <= total_in;
         prev_cyc_ff  <= prev_cyc_in;
         prev_idle_ff <= prev_idle_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      core_ff     <= core_in;
      cyc_ff      <= cyc_in;
      tick_ff     <= tick_in;
      busyt_ff    <= busyt_in;
      first_ff    <= first_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      rsp_pct_ff  <= rsp_pct_in;
      rsp_core_ff <= rsp_core_in;
   end

   // History memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (hist_we) begin
         tick_mem[core_idx] <= tick_ff;
      end
      if (busy_we) begin
         busy_mem[core_idx] <= busyt_ff;
      end
      if (pct_we) begin
         pct_mem[core_idx] <= pct_wdata;
      end
      if (accept) begin
         rd_tick_ff <= tick_mem[req_idx];
         rd_busy_ff <= busy_mem[req_idx];
         rd_pct_ff  <= pct_mem[req_idx];
      end
   end

   // Checks
   a_pct_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.busy_percent <= PCT_FULL))
      else $error("busy percent above 100");

   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.cmd == CMD_SAMPLE) && !req_in_range)
      |=> (rsp_valid && (rsp_data.busy_percent == PCT_NONE)))
      else $error("out-of-range sample did not answer zero next cycle");

   a_leave_floor: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.cmd == CMD_LEAVE) && (nest_ff == 8'd0)) |=> (nest_ff == 8'd0))
      else $error("idle nesting went below zero");

   a_enter_sat: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.cmd == CMD_ENTER) && (nest_ff == NEST_MAX)) |=> (nest_ff == NEST_MAX))
      else $error("idle nesting wrapped past saturation");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (a_ff != 64'd0))
      else $error("divide started with zero divisor");

endmodule

[verif/cpu_utilization_monitor_tb.sv]
// Self-checking testbench for cpu_utilization_monitor: directed and random idle/sample words
// are predicted in-bench and checked field by field. Depends on cpu_util_pkg and the RTL.
module cpu_utilization_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpu_util_pkg::*;

   localparam int CORE_SLOTS = MAX_CORES_DEF;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 10;   // margin for a trailing enter/leave to finish
   localparam int TAIL_CYCLES = 100;    // margin for the longest computed sample (core 0)
   localparam int PRINT_CAP = 100;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic [5:0] csr_wdata;

   int err_count = 0;

   // Expected results, oldest first
   rsp_type pct_expected[$];

   // Predictor state
   logic [5:0]  m_online;
   logic [7:0]  m_depth;
   logic [63:0] m_idle_start;
   logic [63:0] m_idle_sum;
   logic [63:0] m_last_tick [CORE_SLOTS];
   logic [63:0] m_last_busy [CORE_SLOTS];
   logic [63:0] m_last_cyc0;
   logic [63:0] m_last_idle0;
   logic [6:0]  m_pct_hold [CORE_SLOTS];
   logic        m_seen [CORE_SLOTS];

   // Stimulus generator state: plausible, monotonic counters
   logic [63:0] g_cycle = '0;
   logic [63:0] g_tick = '0;
   logic [63:0] g_busy [CORE_SLOTS];
   logic [63:0] g_last_tick [CORE_SLOTS];

   cpu_utilization_monitor dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Timeout
   initial begin
      #10_000_000;
      $display("** cpu_utilization_monitor: FAILED **");
      $finish;
   end

   task automatic report_mismatch(input string what);
      // keep the log short on a badly broken block
      if (err_count < PRINT_CAP)
         $display("ERROR @%0t: %s", $realtime, what);
      err_count++;
   endtask

   // Predict one word; returns 1 when it produces a result
   function automatic bit usage_predict(input req_type w, output rsp_type r);
      logic [63:0] idle_now, d_cyc, d_idle, d_tick, d_busy, q;
      logic [6:0]  pct;
      int          c;
      r = '0;
      pct = PCT_NONE;
      c = w.core_index;
      case (w.cmd)
         CMD_ENTER: begin
            if (m_depth == 0) m_idle_start = w.cycle_stamp;
            if (m_depth != NEST_MAX) m_depth++;
            return 1'b0;
         end
         CMD_LEAVE: begin
            if (m_depth != 0) begin
               if (m_depth == 1) m_idle_sum += w.cycle_stamp - m_idle_start;
               m_depth--;
            end
            return 1'b0;
         end
         CMD_SAMPLE: begin
            if (c < CORE_SLOTS && c < int'(m_online)) begin
               if (m_seen[c] && w.tick_stamp == m_last_tick[c]) begin
                  pct = m_pct_hold[c];
               end else if (c == 0) begin
                  // core 0: cycle and idle-cycle deltas, rounded, capped
                  idle_now = m_idle_sum;
                  if (m_depth != 0) idle_now += w.cycle_stamp - m_idle_start;
                  if (!m_seen[0]) begin
                     d_cyc = '0;
                     d_idle = '0;
                     m_seen[0] = 1'b1;
                  end else begin
                     d_cyc = w.cycle_stamp - m_last_cyc0;
                     d_idle = idle_now - m_last_idle0;
                  end
                  m_last_tick[0] = w.tick_stamp;
                  m_last_cyc0 = w.cycle_stamp;
                  m_last_idle0 = idle_now;
                  if (d_cyc == 0 || d_idle >= d_cyc) begin
                     pct = PCT_NONE;
                  end else begin
                     q = ((d_cyc - d_idle) * 64'd100 + d_cyc / 64'd2) / d_cyc;
                     pct = (q > 64'd100) ? PCT_FULL : q[6:0];
                  end
                  m_pct_hold[0] = pct;
               end else begin
                  // other cores: tick and busy-tick deltas, truncated
                  if (!m_seen[c]) begin
                     d_tick = w.tick_stamp;
                     d_busy = w.core_busy_ticks;
                     m_seen[c] = 1'b1;
                  end else begin
                     d_tick = w.tick_stamp - m_last_tick[c];
                     d_busy = w.core_busy_ticks - m_last_busy[c];
                  end
                  m_last_tick[c] = w.tick_stamp;
                  m_last_busy[c] = w.core_busy_ticks;
                  if (d_tick == 0) begin
                     pct = PCT_NONE;
                  end else if (d_busy >= d_tick) begin
                     pct = PCT_FULL;
                  end else begin
                     q = (d_busy * 64'd100) / d_tick;
                     pct = q[6:0];
                  end
                  m_pct_hold[c] = pct;
               end
            end
            r.busy_percent = pct;
            r.sampled_core = w.core_index;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic req_type make_word(input logic [1:0] cmd, input logic [5:0] core,
                                         input logic [63:0] cyc, input logic [63:0] tick,
                                         input logic [63:0] busy_ticks);
      req_type w;
      w.cmd = cmd;
      w.core_index = core;
      w.cycle_stamp = cyc;
      w.tick_stamp = tick;
      w.core_busy_ticks = busy_ticks;
      return w;
   endfunction

   // Mostly well-formed traffic with random content, plus noise
   function automatic req_type next_word();
      req_type     w;
      int unsigned roll;
      int          c, hi;
      logic [63:0] span;
      w = '0;
      roll = $urandom_range(0, 99);
      g_cycle += 64'($urandom_range(1, 4000));
      if (roll < 70) begin
         w.cycle_stamp = g_cycle;
         w.tick_stamp = g_tick;
         roll = $urandom_range(0, 99);
         if (roll < 13) begin
            w.cmd = CMD_ENTER;
         end else if (roll < 26) begin
            w.cmd = CMD_LEAVE;
         end else begin
            w.cmd = CMD_SAMPLE;
            hi = (m_online > CORE_SLOTS) ? CORE_SLOTS : int'(m_online);
            if (hi == 0 || $urandom_range(0, 3) == 0) c = 0;
            else c = $urandom_range(0, hi - 1);
            if ($urandom_range(0, 4) != 0) g_tick += 64'($urandom_range(1, 60));
            span = g_tick - g_last_tick[c];
            if (span > 64'd100000) span = 64'd1000;
            g_busy[c] += 64'($urandom_range(0, int'(span) + int'(span) / 8));
            g_last_tick[c] = g_tick;
            w.core_index = 6'(c);
            w.tick_stamp = g_tick;
            w.core_busy_ticks = g_busy[c];
         end
      end else begin
         w.cmd = 2'($urandom_range(0, 3));
         w.core_index = 6'($urandom_range(0, 63));
         w.cycle_stamp = {$urandom(), $urandom()};
         // repeat the last tick now and then to hit the cached path
         if (roll < 82) w.tick_stamp = m_last_tick[w.core_index[4:0]];
         else w.tick_stamp = {$urandom(), $urandom()};
         w.core_busy_ticks = {$urandom(), $urandom()};
      end
      return w;
   endfunction

   // Present one word and hold it until the block takes it
   task automatic send_word(input req_type w);
      rsp_type r;
      @(negedge clock);
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (usage_predict(w, r)) pct_expected.push_back(r);
   endtask

   task automatic idle_for(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Wait until every expected result is in and the block has settled
   task automatic drain(input int extra);
      idle_for(1);
      while (pct_expected.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_online(input logic [5:0] value);
      drain(SETTLE_CYCLES);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      m_online = value;
   endtask

   // Result checker
   always @(posedge clock) begin : check_result
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pct_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result core %0d pct %0d",
                                      rsp_data.sampled_core, rsp_data.busy_percent));
         end else begin
            want = pct_expected.pop_front();
            if (rsp_data.busy_percent !== want.busy_percent)
               report_mismatch($sformatf("core %0d busy_percent got %0d want %0d",
                                         want.sampled_core, rsp_data.busy_percent,
                                         want.busy_percent));
            if (rsp_data.sampled_core !== want.sampled_core)
               report_mismatch($sformatf("sampled_core got %0d want %0d",
                                         rsp_data.sampled_core, want.sampled_core));
         end
      end
   end

   // Special cases: first samples, nesting, cached ticks, range limits, extremes
   task automatic test_directed_cases();
      send_word(make_word(CMD_SAMPLE, 6'd0, 64'd1000, 64'd10, 64'd0));
      send_word(make_word(CMD_UNUSED, 6'd0, 64'd1100, 64'd99, 64'd5));
      send_word(make_word(CMD_LEAVE, 6'd0, 64'd1150, 64'd0, 64'd0));
      send_word(make_word(CMD_ENTER, 6'd0, 64'd1200, 64'd0, 64'd0));
      send_word(make_word(CMD_ENTER, 6'd0, 64'd1300, 64'd0, 64'd0));
      send_word(make_word(CMD_LEAVE, 6'd0, 64'd1400, 64'd0, 64'd0));
      send_word(make_word(CMD_LEAVE, 6'd0, 64'd1600, 64'd0, 64'd0));
      send_word(make_word(CMD_SAMPLE, 6'd0, 64'd2000, 64'd11, 64'd7));
      send_word(make_word(CMD_SAMPLE, 6'd0, 64'd2500, 64'd11, 64'd7));
      send_word(make_word(CMD_SAMPLE, 6'd1, 64'd2600, 64'd12, 64'd3));
      send_word(make_word(CMD_SAMPLE, 6'd63, 64'd2700, 64'd13, 64'd3));
      // sample while idle, then close the idle period
      send_word(make_word(CMD_ENTER, 6'd0, 64'd3000, 64'd0, 64'd0));
      send_word(make_word(CMD_SAMPLE, 6'd0, 64'd3100, 64'd14, 64'd0));
      send_word(make_word(CMD_LEAVE, 6'd0, 64'd3200, 64'd0, 64'd0));
      send_word(make_word(CMD_SAMPLE, 6'd0, '1, '1, '1));
      set_online(6'd32);
      send_word(make_word(CMD_SAMPLE, 6'd31, 64'd0, 64'd1000, 64'd250));
      send_word(make_word(CMD_SAMPLE, 6'd31, '1, 64'd2000, 64'd5000));
      send_word(make_word(CMD_SAMPLE, 6'd31, 64'd5, 64'd2000, 64'd1));
      send_word(make_word(CMD_SAMPLE, 6'd5, 64'd0, 64'd0, 64'd0));
      send_word(make_word(CMD_SAMPLE, 6'd7, 64'd0, '1, '1));
      send_word(make_word(CMD_SAMPLE, 6'd32, 64'd0, 64'd50, 64'd10));
      set_online(6'd0);
      send_word(make_word(CMD_SAMPLE, 6'd0, 64'd9000, 64'd77, 64'd0));
      set_online(6'd63);
      send_word(make_word(CMD_SAMPLE, 6'd40, 64'd9100, 64'd78, 64'd1));
      send_word(make_word(CMD_SAMPLE, 6'd2, 64'd9200, 64'd100, 64'd99));
   endtask

   // Depth counter saturates at its top and unwinds back to zero
   task automatic test_nesting_saturation();
      logic [63:0] cyc;
      cyc = {$urandom(), $urandom()};
      send_word(make_word(CMD_SAMPLE, 6'd0, cyc, {$urandom(), $urandom()}, 64'd0));
      repeat (260) begin
         cyc += 64'($urandom_range(1, 50));
         send_word(make_word(CMD_ENTER, 6'($urandom_range(0, 63)), cyc, 64'd0, 64'd0));
      end
      cyc += 64'd500;
      send_word(make_word(CMD_SAMPLE, 6'd0, cyc, {$urandom(), $urandom()}, 64'd0));
      repeat (260) begin
         cyc += 64'($urandom_range(1, 50));
         send_word(make_word(CMD_LEAVE, 6'($urandom_range(0, 63)), cyc, 64'd0, 64'd0));
      end
      cyc += 64'd900;
      send_word(make_word(CMD_SAMPLE, 6'd0, cyc, {$urandom(), $urandom()}, 64'd0));
   endtask

   // Random traffic over several core counts, bursts and gaps on the sender
   task automatic test_random_traffic();
      logic [5:0] settings [6];
      int         burst, gap;
      bit         no_gaps;
      settings[0] = 6'd32;
      settings[1] = 6'd1;
      settings[2] = 6'd63;
      settings[3] = 6'($urandom_range(2, 31));
      settings[4] = 6'd0;
      settings[5] = 6'($urandom_range(1, 63));
      foreach (settings[p]) begin
         set_online(settings[p]);
         no_gaps = (p == 2);
         burst = $urandom_range(1, 12);
         repeat (215) begin
            send_word(next_word());
            if (!no_gaps) begin
               burst--;
               if (burst == 0) begin
                  gap = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 90)
                                                    : $urandom_range(1, 8);
                  idle_for(gap);
                  burst = $urandom_range(1, 12);
               end
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      m_online = ONLINE_RESET;
      m_depth = '0;
      m_idle_start = '0;
      m_idle_sum = '0;
      m_last_cyc0 = '0;
      m_last_idle0 = '0;
      for (int i = 0; i < CORE_SLOTS; i++) begin
         m_last_tick[i] = '0;
         m_last_busy[i] = '0;
         m_pct_hold[i] = PCT_NONE;
         m_seen[i] = 1'b0;
         g_busy[i] = '0;
         g_last_tick[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_nesting_saturation();
      test_random_traffic();

      drain(TAIL_CYCLES);
      if (pct_expected.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pct_expected.size()));
      if (err_count == 0)
         $display("** cpu_utilization_monitor: PASSED **");
      else
         $display("** cpu_utilization_monitor: FAILED **");
      $finish;
   end

endmodule
